### hdl/feedback_frame_deframer_macros.svh
// Assertion macros shared by the feedback frame deframer RTL.
`ifndef FEEDBACK_FRAME_DEFRAMER_MACROS_SVH
`define FEEDBACK_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ffd_pkg.sv
// Shared constants, types and helpers of the feedback frame deframer.
package ffd_pkg;

  localparam int WINDOW_BYTES_DEF  = 48;
  localparam int WINDOW_OFFSET_DEF = 28;
  localparam int REPORT_BYTES_DEF  = 474;

  localparam int BYTE_W      = 8;
  localparam int OUT_INDEX_W = 6;

  localparam logic [7:0] MAGIC_0      = 8'h56;
  localparam logic [7:0] MAGIC_1      = 8'h50;
  localparam logic [7:0] MAGIC_2      = 8'h43;
  localparam logic [7:0] MAGIC_3      = 8'h4D;
  localparam logic [7:0] VERSION      = 8'h05;
  localparam logic [7:0] KIND_REPORT  = 8'h81;
  localparam logic [7:0] KIND_WRAPPED = 8'h83;

  localparam logic [3:0] HDR_KIND    = 4'd5;
  localparam logic [3:0] HDR_LEN_LO  = 4'd6;
  localparam logic [3:0] HDR_LEN_HI  = 4'd7;
  localparam logic [3:0] HDR_LAST    = 4'd15;
  localparam logic [3:0] HDR_CHECKED = 4'd5;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HALT    = 2'd2;

  typedef struct packed {
    logic                   cap_wr;
    logic [OUT_INDEX_W-1:0] cap_addr;
    logic [BYTE_W-1:0]      cap_data;
    logic                   finish;
  } ffd_ctl_t;

  typedef struct packed {
    logic                   busy;
    logic                   load;
    logic [BYTE_W-1:0]      data;
    logic [OUT_INDEX_W-1:0] index;
    logic                   last;
  } ffd_stat_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    logic [7:0] val;
    unique case (pos)
      3'd0:    val = MAGIC_0;
      3'd1:    val = MAGIC_1;
      3'd2:    val = MAGIC_2;
      3'd3:    val = MAGIC_3;
      3'd4:    val = VERSION;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

### hdl/ffd_window.sv
// Window stores with compare sweep and emission sequencer.
module ffd_window #(
  parameter int WINDOW_BYTES = ffd_pkg::WINDOW_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ffd_pkg::ffd_ctl_t  ctl,
  input  logic             out_free,
  output ffd_pkg::ffd_stat_t stat
);
  import ffd_pkg::*;

  localparam int IDX_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(WINDOW_BYTES - 1);

  localparam logic [2:0] W_IDLE   = 3'd0;
  localparam logic [2:0] W_CMP    = 3'd1;
  localparam logic [2:0] W_CMPEND = 3'd2;
  localparam logic [2:0] W_EMRD   = 3'd3;
  localparam logic [2:0] W_EMLD   = 3'd4;

  logic [BYTE_W-1:0] cap_mem  [WINDOW_BYTES];
  logic [BYTE_W-1:0] prev_mem [WINDOW_BYTES];

  logic [2:0]        st;
  logic [IDX_W-1:0]  k;
  logic              have_previous;
  logic              diff;
  logic              chk;
  logic [BYTE_W-1:0] cap_q;
  logic [BYTE_W-1:0] prev_q;
  logic              diff_now;

  assign diff_now = diff | (chk & (cap_q != prev_q));

  always_ff @(posedge clk) begin
    if (ctl.cap_wr) begin
      cap_mem[ctl.cap_addr[IDX_W-1:0]] <= ctl.cap_data;
    end
    if (st == W_EMLD) begin
      prev_mem[k] <= cap_q;
    end
    cap_q  <= cap_mem[k];
    prev_q <= prev_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= W_IDLE;
      k             <= '0;
      have_previous <= 1'b0;
      diff          <= 1'b0;
      chk           <= 1'b0;
    end else begin
      chk <= (st == W_CMP);
      if ((st == W_IDLE) && ctl.finish) begin
        diff <= 1'b0;
      end else begin
        diff <= diff_now;
      end
      unique case (st)
        W_IDLE: begin
          if (ctl.finish) begin
            k    <= '0;
            st   <= have_previous ? W_CMP : W_EMRD;
          end
        end
        W_CMP: begin
          if (k == K_LAST) begin
            st <= W_CMPEND;
          end else begin
            k <= k + 1'b1;
          end
        end
        W_CMPEND: begin
          k  <= '0;
          st <= diff_now ? W_EMRD : W_IDLE;
        end
        W_EMRD: begin
          if (out_free) begin
            st <= W_EMLD;
          end
        end
        W_EMLD: begin
          have_previous <= 1'b1;
          if (k == K_LAST) begin
            st <= W_IDLE;
          end else begin
            k  <= k + 1'b1;
            st <= W_EMRD;
          end
        end
        default: st <= W_IDLE;
      endcase
    end
  end

  always_comb begin
    stat.busy  = (st != W_IDLE);
    stat.load  = (st == W_EMLD);
    stat.data  = cap_q;
    stat.index = OUT_INDEX_W'(k);
    stat.last  = (k == K_LAST);
  end

endmodule

### hdl/feedback_frame_deframer.sv
// Feedback frame deframer: byte-stream frame parser with window change reporting.
//
// The rx_byte channel (in_valid/in_ready) takes one stream byte per cycle while
// the block is parsing. Each frame is a 16-byte header and a payload; report
// frames capture a window of WINDOW_BYTES bytes into an on-chip store.
// Results leave on the out channel (out_valid/out_ready) through one output
// register.
// When a report frame ends and a window was sent before, a compare sweep
// reads the capture and previous stores in parallel, one entry per cycle. If
// the window changed (or nothing was sent yet), each window byte is read,
// loaded and handed over in turn; a stall by the receiver holds the next. During
// the sweep and the emission in_ready is low. A bad magic or version byte
// gives one error result in the next cycle; the block then takes and drops
// every byte until reset. Reset is synchronous and clears the parser and the
// emission sequencer; window stores are not cleared. While the receiver
// stalls with a result pending, further items are taken only if the
// output register is free or being emptied in the same cycle.
`include "feedback_frame_deframer_macros.svh"

module feedback_frame_deframer #(
  parameter int WINDOW_BYTES  = ffd_pkg::WINDOW_BYTES_DEF,
  parameter int WINDOW_OFFSET = ffd_pkg::WINDOW_OFFSET_DEF,
  parameter int REPORT_BYTES  = ffd_pkg::REPORT_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ffd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ffd_pkg::BYTE_W-1:0]      out_byte,
  output logic [ffd_pkg::OUT_INDEX_W-1:0] out_index,
  output logic                            error,
  output logic                            last
);
  import ffd_pkg::*;

  localparam logic [16:0] REPORT_LEN  = 17'(REPORT_BYTES);
  localparam logic [16:0] WRAPPED_LEN = 17'(REPORT_BYTES + 2);
  localparam logic [15:0] PREFIX_OK   = 16'(REPORT_BYTES);

  logic [1:0]  phase;
  logic [3:0]  header_count;
  logic [7:0]  frame_kind;
  logic [15:0] payload_length;
  logic [15:0] payload_count;
  logic [15:0] prefix_word;

  ffd_ctl_t  ctl;
  ffd_stat_t stat;

  logic        accept;
  logic        is_report;
  logic        is_wrapped;
  logic        len_ok;
  logic        bad_magic;
  logic        frame_end;
  logic [16:0] win_lo;
  logic [16:0] rep_end;
  logic [16:0] idx;
  logic [16:0] rel;
  logic        in_window;

  assign in_ready = !stat.busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign is_report  = (frame_kind == KIND_REPORT);
  assign is_wrapped = (frame_kind == KIND_WRAPPED);
  assign len_ok     = (is_report && ({1'b0, payload_length} >= REPORT_LEN)) ||
                      (is_wrapped && ({1'b0, payload_length} >= WRAPPED_LEN));
  assign bad_magic  = (phase == PH_HEADER) && (header_count < HDR_CHECKED) &&
                      (rx_byte != magic_byte(header_count[2:0]));
  assign frame_end  = ({1'b0, payload_count} + 17'd1 >= {1'b0, payload_length});

  assign win_lo    = 17'(WINDOW_OFFSET) + (is_wrapped ? 17'd2 : 17'd0);
  assign rep_end   = REPORT_LEN + (is_wrapped ? 17'd2 : 17'd0);
  assign idx       = {1'b0, payload_count};
  assign rel       = idx - win_lo;
  assign in_window = (idx >= win_lo) && (rel < 17'(WINDOW_BYTES)) && (idx < rep_end);

  always_comb begin
    ctl.cap_wr   = accept && (phase == PH_PAYLOAD) && len_ok && in_window;
    ctl.cap_addr = rel[OUT_INDEX_W-1:0];
    ctl.cap_data = rx_byte;
    ctl.finish   = accept && (phase == PH_PAYLOAD) && frame_end && len_ok &&
                   (!is_wrapped || (prefix_word == PREFIX_OK));
  end

  ffd_window #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .out_free(!out_valid),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      frame_kind     <= '0;
      payload_length <= '0;
      payload_count  <= '0;
      prefix_word    <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (bad_magic) begin
            phase <= PH_HALT;
          end else begin
            if (header_count == HDR_KIND) begin
              frame_kind <= rx_byte;
            end
            if (header_count == HDR_LEN_LO) begin
              payload_length[7:0] <= rx_byte;
            end
            if (header_count == HDR_LEN_HI) begin
              payload_length[15:8] <= rx_byte;
            end
            if (header_count == HDR_LAST) begin
              header_count  <= '0;
              payload_count <= '0;
              prefix_word   <= '0;
              phase         <= (payload_length != 16'd0) ? PH_PAYLOAD : PH_HEADER;
            end else begin
              header_count <= header_count + 4'd1;
            end
          end
        end
        PH_PAYLOAD: begin
          if (is_wrapped && (payload_count == 16'd0)) begin
            prefix_word[7:0] <= rx_byte;
          end
          if (is_wrapped && (payload_count == 16'd1)) begin
            prefix_word[15:8] <= rx_byte;
          end
          if (frame_end) begin
            phase        <= PH_HEADER;
            header_count <= '0;
          end else begin
            payload_count <= payload_count + 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      priority if (accept && bad_magic) begin
        out_valid <= 1'b1;
      end else if (stat.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (accept && bad_magic) begin
      out_byte  <= '0;
      out_index <= '0;
      error     <= 1'b1;
      last      <= 1'b1;
    end else if (stat.load) begin
      out_byte  <= stat.data;
      out_index <= stat.index;
      error     <= 1'b0;
      last      <= stat.last;
    end
  end

  `FFD_ASSERT_NOW(a_error_halts, out_valid && error, phase == PH_HALT,
    "Error result pending while the parser is not halted.")
  `FFD_ASSERT_NOW(a_load_free, stat.load, !out_valid,
    "Window byte loaded into a full output register.")
  `FFD_ASSERT_NEXT(a_halt_silent, (phase == PH_HALT) && !out_valid, !out_valid,
    "Result produced after the block halted.")

endmodule
